// File: rtl/bba_pkg.sv
// Shared types, codes and helpers for the buddy block allocator.
// No dependencies; imported by every other file of the block.
package bba_pkg;

  localparam int ORD_W      = 3;
  localparam int OWN_W      = 16;
  localparam int SIZE_W     = 7;
  localparam int CNT_OUT_W  = 7;
  localparam int NEED_MAX   = 7;
  localparam int RESULT_CAP = 64;
  localparam int QK_W       = $clog2(RESULT_CAP);
  localparam logic [ORD_W-1:0] RESET_ORDER = 3'd6;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] STAT_ALLOC = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_LIST  = 2'd2;

  typedef struct packed {
    logic              action;
    logic [OWN_W-1:0]  owner_id;
    logic [SIZE_W-1:0] request_size;
  } in_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] block_count;
    logic [OWN_W-1:0]     entry_owner;
    logic                 last_entry;
  } out_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_PICK,
    S_SPLIT,
    S_COMMIT,
    S_REPLY,
    S_Q_RD,
    S_Q_EV
  } state_t;

  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic scan_rd;
    logic scan_ev;
    logic mark_nofit;
    logic pick;
    logic split;
    logic commit;
    logic reply;
    logic q_start;
    logic q_rd;
    logic q_emit;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic too_big;
    logic scan_last;
    logic pick_ok;
    logic split_need;
    logic out_free;
    logic q_last;
  } stat_t;

  function automatic logic [ORD_W-1:0] order_of(input logic [SIZE_W-1:0] size);
    logic [ORD_W-1:0] o;
    logic [SIZE_W:0]  pw;
    o = ORD_W'(NEED_MAX);
    for (int i = NEED_MAX - 1; i >= 0; i--) begin
      pw = (SIZE_W + 1)'(1) << i;
      if (pw >= {1'b0, size}) o = ORD_W'(i);
    end
    return o;
  endfunction

endpackage

// File: rtl/bba_ctrl.sv
// Sequencing state machine of the buddy block allocator.
// Depends on bba_pkg; drives bba_datapath through cmd_t, reads stat_t.
module bba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bba_pkg::stat_t st,
  output bba_pkg::cmd_t  cmd
);
  import bba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (st.is_query)     state_nxt = S_Q_RD;
        else if (st.too_big) state_nxt = S_REPLY;
        else                 state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: state_nxt = st.scan_last ? S_PICK : S_SCAN_RD;
      S_PICK:    state_nxt = st.pick_ok ? S_SPLIT : S_REPLY;
      S_SPLIT:   if (!st.split_need) state_nxt = S_COMMIT;
      S_COMMIT:  state_nxt = S_REPLY;
      S_REPLY:   if (st.out_free) state_nxt = S_IDLE;
      S_Q_RD:    state_nxt = S_Q_EV;
      S_Q_EV:    if (st.out_free) state_nxt = st.q_last ? S_IDLE : S_Q_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        if (st.is_query)     cmd.q_start    = 1'b1;
        else if (st.too_big) cmd.mark_nofit = 1'b1;
        else                 cmd.scan_start = 1'b1;
      end
      S_SCAN_RD: cmd.scan_rd = 1'b1;
      S_SCAN_EV: cmd.scan_ev = 1'b1;
      S_PICK: begin
        if (st.pick_ok) cmd.pick       = 1'b1;
        else            cmd.mark_nofit = 1'b1;
      end
      S_SPLIT:  cmd.split  = st.split_need;
      S_COMMIT: cmd.commit = 1'b1;
      S_REPLY:  cmd.reply  = st.out_free;
      S_Q_RD:   cmd.q_rd   = 1'b1;
      S_Q_EV:   cmd.q_emit = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: rtl/bba_datapath.sv
// Slot table memory, scan trackers, split logic and result register.
// Depends on bba_pkg; commanded by bba_ctrl through cmd_t.
module bba_datapath #(
  parameter int MAX_ORDER = 6,
  parameter int SLOTS     = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  input  bba_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::out_req_t out_data,
  input  bba_pkg::cmd_t     cmd,
  output bba_pkg::stat_t    st
);
  import bba_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MEM_W = ORD_W + CNT_W + OWN_W;
  localparam logic [CNT_W-1:0] END_MARK = CNT_W'(SLOTS);

  logic [MEM_W-1:0] mem [SLOTS];

  logic [ORD_W-1:0] total_order_r;
  logic [CNT_W-1:0] used_r;
  logic             slot0_ok_r;
  logic             rd_init_r;
  logic [MEM_W-1:0] rdata_r;
  in_req_t          in_r;
  logic             nofit_r;

  logic [IDX_W-1:0] scan_k_r;
  logic             ex_hit_r, bs_hit_r;
  logic [IDX_W-1:0] ex_slot_r, bs_slot_r;
  logic [CNT_W-1:0] ex_next_r, bs_next_r;
  logic [ORD_W-1:0] bs_ord_r;

  logic [IDX_W-1:0] m_slot_r;
  logic [ORD_W-1:0] m_ord_r;
  logic [CNT_W-1:0] m_next_r;

  logic [IDX_W-1:0] q_cur_r;
  logic [QK_W-1:0]  q_k_r;

  logic             out_valid_r;
  out_req_t         out_data_r;

  logic [ORD_W-1:0] need;
  logic [ORD_W-1:0] e_ord;
  logic [CNT_W-1:0] e_next;
  logic [OWN_W-1:0] e_own;
  logic             ovf;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] raddr, waddr;
  logic [MEM_W-1:0] wdata;
  logic [ORD_W-1:0] cfg_order;

  assign need = order_of(in_r.request_size);

  always_comb begin
    if (rd_init_r) begin
      e_ord  = total_order_r;
      e_next = END_MARK;
      e_own  = '0;
    end else begin
      e_ord  = rdata_r[MEM_W-1 -: ORD_W];
      e_next = rdata_r[OWN_W +: CNT_W];
      e_own  = rdata_r[OWN_W-1:0];
    end
  end

  assign ovf = ({1'b0, used_r} + (CNT_W + 1)'(bs_ord_r - need)) > (CNT_W + 1)'(SLOTS);

  always_comb begin
    st.is_query   = (in_r.action == ACT_QUERY);
    st.too_big    = (need > total_order_r);
    st.scan_last  = ((CNT_W'(scan_k_r) + CNT_W'(1)) == used_r);
    st.pick_ok    = ex_hit_r || (bs_hit_r && !ovf);
    st.split_need = (m_ord_r > need);
    st.out_free   = !out_valid_r || out_ready;
    st.q_last     = (e_next >= used_r) || (e_next >= END_MARK) ||
                    (q_k_r == QK_W'(RESULT_CAP - 1));
  end

  always_comb begin
    rd_en = cmd.scan_rd || cmd.q_rd;
    raddr = cmd.q_rd ? q_cur_r : scan_k_r;
    wr_en = cmd.split || cmd.commit;
    waddr = cmd.commit ? m_slot_r : used_r[IDX_W-1:0];
    wdata = cmd.commit ? {m_ord_r, m_next_r, in_r.owner_id}
                       : {m_ord_r - ORD_W'(1), m_next_r, OWN_W'(0)};
  end

  always_comb begin
    if (int'(cfg_wdata) > MAX_ORDER) cfg_order = ORD_W'(MAX_ORDER);
    else                             cfg_order = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_order_r <= RESET_ORDER;
      used_r        <= CNT_W'(1);
      slot0_ok_r    <= 1'b0;
      rd_init_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      nofit_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_order_r <= cfg_order;
        used_r        <= CNT_W'(1);
        slot0_ok_r    <= 1'b0;
      end
      if (cmd.split) used_r <= used_r + CNT_W'(1);
      if (cmd.commit && (m_slot_r == '0)) slot0_ok_r <= 1'b1;
      if (rd_en) rd_init_r <= (raddr == '0) && !slot0_ok_r;
      if (cmd.load_in)    nofit_r <= 1'b0;
      if (cmd.mark_nofit) nofit_r <= 1'b1;
      if (cmd.reply || cmd.q_emit) out_valid_r <= 1'b1;
      else if (out_ready)          out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.scan_start) begin
      scan_k_r <= '0;
      ex_hit_r <= 1'b0;
      bs_hit_r <= 1'b0;
    end
    if (cmd.scan_ev) begin
      scan_k_r <= scan_k_r + IDX_W'(1);
      if (e_own == '0) begin
        if ((e_ord == need) && !ex_hit_r) begin
          ex_hit_r  <= 1'b1;
          ex_slot_r <= scan_k_r;
          ex_next_r <= e_next;
        end
        if ((e_ord > need) && (!bs_hit_r || (e_ord < bs_ord_r))) begin
          bs_hit_r  <= 1'b1;
          bs_slot_r <= scan_k_r;
          bs_next_r <= e_next;
          bs_ord_r  <= e_ord;
        end
      end
    end
    if (cmd.pick) begin
      if (ex_hit_r) begin
        m_slot_r <= ex_slot_r;
        m_ord_r  <= need;
        m_next_r <= ex_next_r;
      end else begin
        m_slot_r <= bs_slot_r;
        m_ord_r  <= bs_ord_r;
        m_next_r <= bs_next_r;
      end
    end
    if (cmd.split) begin
      m_ord_r  <= m_ord_r - ORD_W'(1);
      m_next_r <= used_r;
    end
    if (cmd.q_start) begin
      q_cur_r <= '0;
      q_k_r   <= '0;
    end
    if (cmd.q_emit) begin
      q_cur_r <= e_next[IDX_W-1:0];
      q_k_r   <= q_k_r + QK_W'(1);
      out_data_r.status      <= STAT_LIST;
      out_data_r.block_count <= CNT_OUT_W'(used_r);
      out_data_r.entry_owner <= e_own;
      out_data_r.last_entry  <= st.q_last;
    end
    if (cmd.reply) begin
      out_data_r.status      <= nofit_r ? STAT_NOFIT : STAT_ALLOC;
      out_data_r.block_count <= CNT_OUT_W'(used_r);
      out_data_r.entry_owner <= '0;
      out_data_r.last_entry  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/buddy_block_allocator.sv
// Buddy block allocator top level. Allocate: the table scan reads each of the N blocks in
// the pool through the one memory read port, then S splits follow before the reply. Query:
// one slot read per listed block. One request at a time; the result register frees the
// input side once a result is loaded.
// Reset (synchronous, rst_n low): one free block of order 6; a cfg write reinitializes
// the pool at the new order. No clearing pass: a fill count guards the table.
module buddy_block_allocator #(
  parameter int MAX_ORDER = 6,
  parameter int SLOTS     = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::out_req_t out_data
);
  import bba_pkg::*;

  cmd_t  cmd;
  stat_t st;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bba_datapath #(
    .MAX_ORDER (MAX_ORDER),
    .SLOTS     (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// File: rtl/bba_checker.sv
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg.
module bba_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input bba_pkg::out_req_t out_data
);
  import bba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_alloc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_LIST) |-> out_data.last_entry)
    else $error("allocate result without last marker");

  a_alloc_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_LIST) |-> (out_data.entry_owner == '0))
    else $error("allocate result carries an owner");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_ALLOC) || (out_data.status == STAT_NOFIT) ||
                  (out_data.status == STAT_LIST))
    else $error("undefined status code");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
